[rtl/core/lasc_pkg.sv]
// ----------------------------------------------------------------------------
// lasc_pkg
// Shared constants, codes and controller/datapath interface types for the
// local alignment score and traceback core.
// ----------------------------------------------------------------------------
package lasc_pkg;

    // sequence capacity and derived widths
    localparam int MAX_LEN = 32;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int DIR_D   = MAX_LEN * MAX_LEN;
    localparam int DIR_AW  = $clog2(DIR_D);
    localparam int SC_W    = 11;
    localparam int CFG_W   = 3;
    localparam logic [7:0] GAP_CHAR  = 8'd45;
    localparam logic [7:0] SCORE_MAX = 8'd255;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] MATCH_RST    = 3'd3;
    localparam logic [CFG_W-1:0] MISMATCH_RST = 3'd1;
    localparam logic [CFG_W-1:0] GAP_RST      = 3'd2;

    typedef enum logic [1:0] {
        REG_MATCH    = 2'd0,
        REG_MISMATCH = 2'd1,
        REG_GAP      = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ACT_ROW   = 2'd0,
        ACT_COL   = 2'd1,
        ACT_TB    = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_CELL  = 2'd0,
        KIND_PAIR  = 2'd1,
        KIND_FINAL = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        DIR_DIAG = 2'd0,
        DIR_UP   = 2'd1,
        DIR_LEFT = 2'd2
    } dir_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic row_wr;
        logic col_start;
        logic cell_step;
        logic clear;
        logic tb_init;
        logic emit_final;
        logic tb_read;
        logic tb_step;
        logic emit_flag;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        action_t action;
        logic    out_free;
        logic    row_ignore;
        logic    col_full;
        logic    rows_zero;
        logic    last_cell;
        logic    tb_empty;
        logic    tb_done_next;
    } sts_t;

endpackage

[rtl/core/local_alignment_score_traceback_core.sv]
// ----------------------------------------------------------------------------
// local_alignment_score_traceback_core
// Local alignment scorer with linear gap penalty and traceback.
// ----------------------------------------------------------------------------
// Usage:
//   s_ beats carry an action and a symbol: load row symbol, column symbol,
//   traceback or clear. Row symbols (up to 32) must come before any column.
//   A column symbol yields one beat per stored row with the cell score,
//   top row first; tlast marks the bottom cell. A traceback yields the
//   final bottom-right score, then aligned pairs from the end backwards.
//   An ignored symbol yields one beat with the overflow flag.
//   cfg_we/cfg_index/cfg_data write match bonus, mismatch and gap penalty;
//   write them only while the core is idle.
// Operation:
//   one beat is handled at a time; in a column the cell loop scores one
//   row per cycle while m_ is free, against the score and direction stores.
//   Traceback emits the final score, then reads the direction store and
//   emits one aligned pair per step.
//   A stalled m_ side holds the current beat in the output register and
//   freezes the walk; s_tready drops while a beat is being processed.
//   Reset restores default penalties and empties both sequences.
// ----------------------------------------------------------------------------
module local_alignment_score_traceback_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration writes
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [lasc_pkg::CFG_W-1:0] cfg_data,
    // input beats
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,  // action[1:0], symbol[9:2]
    // result beats
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [47:0]                m_tdata,  // kind[1:0], score[9:2], row[15:10],
                                                 // column[21:16], top_char[29:22],
                                                 // top_gap[30], bottom_char[38:31],
                                                 // bottom_gap[39], overflow[40]
    output logic                       m_tlast
);

    lasc_pkg::cmd_t cmd;
    lasc_pkg::sts_t sts;

    lasc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lasc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

[rtl/core/lasc_ram.sv]
// ----------------------------------------------------------------------------
// lasc_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lasc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read, data holds while not read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/lasc_ctrl.sv]
// ----------------------------------------------------------------------------
// lasc_ctrl
// Sequencer: decodes each accepted beat and steps the datapath through row
// load, column computation, traceback or clear.
// ----------------------------------------------------------------------------
module lasc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  lasc_pkg::sts_t  sts,
    output lasc_pkg::cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_DECODE  = 7'b0000010,
        ST_FLAG    = 7'b0000100,
        ST_CELL    = 7'b0001000,
        ST_TB_FIN  = 7'b0010000,
        ST_TB_RD   = 7'b0100000,
        ST_TB_EMIT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (sts.action)
                    lasc_pkg::ACT_ROW: begin
                        if (sts.row_ignore) begin
                            state_next = ST_FLAG;
                        end else begin
                            cmd.row_wr = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    lasc_pkg::ACT_COL: begin
                        if (sts.col_full) begin
                            state_next = ST_FLAG;
                        end else begin
                            cmd.col_start = 1'b1;
                            state_next    = sts.rows_zero ? ST_IDLE : ST_CELL;
                        end
                    end
                    lasc_pkg::ACT_TB: begin
                        cmd.tb_init = 1'b1;
                        state_next  = ST_TB_FIN;
                    end
                    default: begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_FLAG: begin
                if (sts.out_free) begin
                    cmd.emit_flag = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_CELL: begin
                if (sts.out_free) begin
                    cmd.cell_step = 1'b1;
                    if (sts.last_cell) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TB_FIN: begin
                if (sts.out_free) begin
                    cmd.emit_final = 1'b1;
                    state_next     = sts.tb_empty ? ST_IDLE : ST_TB_RD;
                end
            end
            ST_TB_RD: begin
                cmd.tb_read = 1'b1;
                state_next  = ST_TB_EMIT;
            end
            ST_TB_EMIT: begin
                if (sts.out_free) begin
                    cmd.tb_step = 1'b1;
                    state_next  = sts.tb_done_next ? ST_IDLE : ST_TB_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/lasc_dp.sv]
// ----------------------------------------------------------------------------
// lasc_dp
// Datapath: configuration, lengths, sequence and score stores, direction
// store, cell scoring unit, traceback walker and the output register.
// ----------------------------------------------------------------------------
module lasc_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [lasc_pkg::CFG_W-1:0]    cfg_data,
    input  logic [15:0]                   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,
    output logic                          m_tlast,
    input  lasc_pkg::cmd_t                cmd,
    output lasc_pkg::sts_t                sts
);

    localparam int IW = lasc_pkg::IDX_W;
    localparam int LW = lasc_pkg::LEN_W;
    localparam int SW = lasc_pkg::SC_W;
    localparam int AW = lasc_pkg::DIR_AW;

    logic [lasc_pkg::CFG_W-1:0] match_reg, mismatch_reg, gap_reg;
    lasc_pkg::action_t          act_reg;
    logic [7:0]                 sym_reg;
    logic [LW-1:0]              rl_reg, cl_reg, i_reg, j_reg;
    logic [IW-1:0]              col_idx_reg;
    logic [7:0]                 above_reg, diag_reg;
    logic [lasc_pkg::MAX_LEN-1:0] valid_reg;

    // output register
    logic        out_valid_reg, out_last_reg, out_gap_t_reg, out_gap_b_reg, out_ovf_reg;
    logic [1:0]  out_kind_reg;
    logic [7:0]  out_score_reg, out_tch_reg, out_bch_reg;
    logic [5:0]  out_row_reg, out_col_reg;

    // next contents of the output register
    logic        out_last_next, out_gap_t_next, out_gap_b_next, out_ovf_next;
    logic [1:0]  out_kind_next;
    logic [7:0]  out_score_next, out_tch_next, out_bch_next;
    logic [5:0]  out_row_next, out_col_next;
    logic        out_load;

    // store ports
    logic [7:0]  row_rdata, col_rdata, prv_rdata;
    logic [1:0]  dir_rdata;
    logic [IW-1:0] row_raddr, prv_raddr;
    logic [AW-1:0] dir_waddr, dir_raddr;
    logic        row_ren, prv_ren;

    logic [LW-1:0] im1, jm1, rlm1;
    logic          out_free;
    logic          left_valid, fin_valid;
    logic          walk_done;
    logic [7:0]    left_src, best_sc;
    logic signed [SW-1:0] up_s, left_s, diag_s, best_s;
    lasc_pkg::dir_t best_dir, tb_dir;

    assign im1  = i_reg - LW'(1);
    assign jm1  = j_reg - LW'(1);
    assign rlm1 = rl_reg - LW'(1);
    assign out_free = !out_valid_reg || m_tready;

    // status to the controller
    assign sts.action       = act_reg;
    assign sts.out_free     = out_free;
    assign sts.row_ignore   = (rl_reg == LW'(lasc_pkg::MAX_LEN)) || (cl_reg != '0);
    assign sts.col_full     = (cl_reg == LW'(lasc_pkg::MAX_LEN));
    assign sts.rows_zero    = (rl_reg == '0);
    assign sts.last_cell    = (i_reg == rl_reg);
    assign sts.tb_empty     = (rl_reg == '0) || (cl_reg == '0);
    assign sts.tb_done_next = walk_done;

    // traceback step direction and end of walk
    assign tb_dir = lasc_pkg::dir_t'(dir_rdata);
    always_comb begin
        case (tb_dir)
            lasc_pkg::DIR_DIAG: walk_done = (i_reg == LW'(1)) || (j_reg == LW'(1));
            lasc_pkg::DIR_UP:   walk_done = (i_reg == LW'(1));
            default:            walk_done = (j_reg == LW'(1));
        endcase
    end

    // store addressing
    assign row_ren   = cmd.col_start || cmd.cell_step || cmd.tb_read;
    assign row_raddr = cmd.tb_read ? im1[IW-1:0] : (cmd.col_start ? '0 : i_reg[IW-1:0]);
    assign prv_ren   = cmd.col_start || cmd.cell_step || cmd.tb_init;
    assign prv_raddr = cmd.tb_init ? rlm1[IW-1:0] : (cmd.col_start ? '0 : i_reg[IW-1:0]);
    assign dir_waddr = AW'(im1[IW-1:0]) * AW'(lasc_pkg::MAX_LEN) + AW'(col_idx_reg);
    assign dir_raddr = AW'(im1[IW-1:0]) * AW'(lasc_pkg::MAX_LEN) + AW'(jm1[IW-1:0]);

    lasc_ram #(.WIDTH(8), .DEPTH(lasc_pkg::MAX_LEN)) u_row_ram (
        .aclk    (aclk),
        .wr_en   (cmd.row_wr),
        .wr_addr (rl_reg[IW-1:0]),
        .wr_data (sym_reg),
        .rd_en   (row_ren),
        .rd_addr (row_raddr),
        .rd_data (row_rdata)
    );

    lasc_ram #(.WIDTH(8), .DEPTH(lasc_pkg::MAX_LEN)) u_col_ram (
        .aclk    (aclk),
        .wr_en   (cmd.col_start),
        .wr_addr (cl_reg[IW-1:0]),
        .wr_data (sym_reg),
        .rd_en   (cmd.tb_read),
        .rd_addr (jm1[IW-1:0]),
        .rd_data (col_rdata)
    );

    lasc_ram #(.WIDTH(8), .DEPTH(lasc_pkg::MAX_LEN)) u_prv_ram (
        .aclk    (aclk),
        .wr_en   (cmd.cell_step),
        .wr_addr (im1[IW-1:0]),
        .wr_data (best_sc),
        .rd_en   (prv_ren),
        .rd_addr (prv_raddr),
        .rd_data (prv_rdata)
    );

    lasc_ram #(.WIDTH(2), .DEPTH(lasc_pkg::DIR_D)) u_dir_ram (
        .aclk    (aclk),
        .wr_en   (cmd.cell_step),
        .wr_addr (dir_waddr),
        .wr_data (best_dir),
        .rd_en   (cmd.tb_read),
        .rd_addr (dir_raddr),
        .rd_data (dir_rdata)
    );

    // cell scoring: unwritten previous scores read as zero
    assign left_valid = valid_reg[im1[IW-1:0]];
    assign fin_valid  = valid_reg[rlm1[IW-1:0]];
    assign left_src   = left_valid ? prv_rdata : 8'd0;

    always_comb begin
        up_s   = $signed({{(SW-8){1'b0}}, above_reg}) - $signed(SW'(gap_reg));
        left_s = $signed({{(SW-8){1'b0}}, left_src}) - $signed(SW'(gap_reg));
        if (row_rdata == sym_reg) begin
            diag_s = $signed({{(SW-8){1'b0}}, diag_reg}) + $signed(SW'(match_reg));
        end else begin
            diag_s = $signed({{(SW-8){1'b0}}, diag_reg}) - $signed(SW'(mismatch_reg));
        end
        // edge rules, then best of diagonal, up, left in tie order
        if (i_reg == LW'(1) && col_idx_reg == '0) begin
            best_s = diag_s;  best_dir = lasc_pkg::DIR_DIAG;
        end else if (i_reg == LW'(1)) begin
            best_s = left_s;  best_dir = lasc_pkg::DIR_LEFT;
        end else if (col_idx_reg == '0) begin
            best_s = up_s;    best_dir = lasc_pkg::DIR_UP;
        end else if (diag_s >= up_s && diag_s >= left_s) begin
            best_s = diag_s;  best_dir = lasc_pkg::DIR_DIAG;
        end else if (up_s >= left_s) begin
            best_s = up_s;    best_dir = lasc_pkg::DIR_UP;
        end else begin
            best_s = left_s;  best_dir = lasc_pkg::DIR_LEFT;
        end
        // clamp to byte range
        if (best_s < 0) begin
            best_sc = 8'd0;
        end else if (best_s > $signed(SW'(lasc_pkg::SCORE_MAX))) begin
            best_sc = lasc_pkg::SCORE_MAX;
        end else begin
            best_sc = best_s[7:0];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg    <= lasc_pkg::MATCH_RST;
            mismatch_reg <= lasc_pkg::MISMATCH_RST;
            gap_reg      <= lasc_pkg::GAP_RST;
        end else if (cfg_we) begin
            case (lasc_pkg::reg_idx_t'(cfg_index))
                lasc_pkg::REG_MATCH:    match_reg    <= cfg_data;
                lasc_pkg::REG_MISMATCH: mismatch_reg <= cfg_data;
                lasc_pkg::REG_GAP:      gap_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // lengths and valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rl_reg    <= '0;
            cl_reg    <= '0;
            valid_reg <= '0;
        end else begin
            if (cmd.clear) begin
                rl_reg    <= '0;
                cl_reg    <= '0;
                valid_reg <= '0;
            end
            if (cmd.row_wr) begin
                rl_reg <= rl_reg + LW'(1);
            end
            if (cmd.col_start) begin
                cl_reg <= cl_reg + LW'(1);
            end
            if (cmd.cell_step) begin
                valid_reg[im1[IW-1:0]] <= 1'b1;
            end
        end
    end

    // input beat latch and working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            act_reg <= lasc_pkg::action_t'(s_tdata[1:0]);
            sym_reg <= s_tdata[9:2];
        end
        if (cmd.col_start) begin
            col_idx_reg <= cl_reg[IW-1:0];
            i_reg       <= LW'(1);
            above_reg   <= 8'd0;
            diag_reg    <= 8'd0;
        end
        if (cmd.cell_step) begin
            i_reg     <= i_reg + LW'(1);
            above_reg <= best_sc;
            diag_reg  <= left_src;
        end
        if (cmd.tb_init) begin
            i_reg <= rl_reg;
            j_reg <= cl_reg;
        end
        if (cmd.tb_step) begin
            case (tb_dir)
                lasc_pkg::DIR_DIAG: begin
                    i_reg <= im1;
                    j_reg <= jm1;
                end
                lasc_pkg::DIR_UP: i_reg <= im1;
                default:          j_reg <= jm1;
            endcase
        end
    end

    // output register: loads a new beat when empty or being taken
    assign out_load = cmd.emit_flag || cmd.cell_step || cmd.emit_final || cmd.tb_step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // fields of the next result beat
    always_comb begin
        out_kind_next  = lasc_pkg::KIND_CELL;
        out_score_next = 8'd0;
        out_row_next   = 6'd0;
        out_col_next   = 6'd0;
        out_tch_next   = 8'd0;
        out_gap_t_next = 1'b0;
        out_bch_next   = 8'd0;
        out_gap_b_next = 1'b0;
        out_ovf_next   = 1'b0;
        out_last_next  = 1'b1;
        if (cmd.emit_flag) begin
            out_ovf_next = 1'b1;
        end
        if (cmd.cell_step) begin
            out_score_next = best_sc;
            out_row_next   = 6'(i_reg);
            out_col_next   = 6'(col_idx_reg) + 6'd1;
            out_last_next  = (i_reg == rl_reg);
        end
        if (cmd.emit_final) begin
            out_kind_next  = lasc_pkg::KIND_FINAL;
            out_score_next = (!sts.tb_empty && fin_valid) ? prv_rdata : 8'd0;
            out_row_next   = 6'(rl_reg);
            out_col_next   = 6'(cl_reg);
            out_last_next  = sts.tb_empty;
        end
        if (cmd.tb_step) begin
            out_kind_next = lasc_pkg::KIND_PAIR;
            out_row_next  = 6'(i_reg);
            out_col_next  = 6'(j_reg);
            out_last_next = walk_done;
            case (tb_dir)
                lasc_pkg::DIR_DIAG: begin
                    out_tch_next = row_rdata;
                    out_bch_next = col_rdata;
                end
                lasc_pkg::DIR_UP: begin
                    out_tch_next   = row_rdata;
                    out_bch_next   = lasc_pkg::GAP_CHAR;
                    out_gap_b_next = 1'b1;
                end
                default: begin
                    out_tch_next   = lasc_pkg::GAP_CHAR;
                    out_gap_t_next = 1'b1;
                    out_bch_next   = col_rdata;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_kind_reg  <= out_kind_next;
            out_score_reg <= out_score_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            out_tch_reg   <= out_tch_next;
            out_gap_t_reg <= out_gap_t_next;
            out_bch_reg   <= out_bch_next;
            out_gap_b_reg <= out_gap_b_next;
            out_ovf_reg   <= out_ovf_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, out_ovf_reg, out_gap_b_reg, out_bch_reg, out_gap_t_reg,
                       out_tch_reg, out_col_reg, out_row_reg, out_score_reg, out_kind_reg};

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the local alignment score and traceback core.
// A scoreboard predicts cell scores, final scores and aligned pairs for every
// accepted input beat. It compares each output beat field by field in order.
// Stimulus runs from directed corner cases to random alignment sequences,
// with random idling on both sides and several penalty settings.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct {
        lasc_pkg::kind_t kind;
        logic [7:0] score;
        logic [5:0] row;
        logic [5:0] column;
        logic [7:0] top_char;
        logic       top_gap;
        logic [7:0] bottom_char;
        logic       bottom_gap;
        logic       overflow;
        logic       last;
    } align_beat_t;

    // alignment predictor and store of expected output beats
    class align_scoreboard;
        align_beat_t pending_beats[$];
        logic [7:0]  row_seq[lasc_pkg::MAX_LEN];
        logic [7:0]  col_seq[lasc_pkg::MAX_LEN];
        int          n_rows;
        int          n_cols;
        int          col_scores[lasc_pkg::MAX_LEN];
        lasc_pkg::dir_t dir_mem[lasc_pkg::MAX_LEN*lasc_pkg::MAX_LEN];
        int          bonus;
        int          mismatch;
        int          gap;
        int          errors;
        int          n_checked;

        function void reset_state();
            bonus = int'(lasc_pkg::MATCH_RST);
            mismatch = int'(lasc_pkg::MISMATCH_RST);
            gap = int'(lasc_pkg::GAP_RST);
            n_rows = 0;
            n_cols = 0;
            foreach (col_scores[i]) col_scores[i] = 0;
            pending_beats.delete();
        endfunction

        function void set_reg(lasc_pkg::reg_idx_t idx, int val);
            case (idx)
                lasc_pkg::REG_MATCH:    bonus = val;
                lasc_pkg::REG_MISMATCH: mismatch = val;
                lasc_pkg::REG_GAP:      gap = val;
                default: ;
            endcase
        endfunction

        function void push(lasc_pkg::kind_t k, int sc, int r, int c, int tc, bit tg,
                           int bc, bit bg, bit ov);
            align_beat_t b;
            b.kind = k;
            b.score = 8'(sc);
            b.row = 6'(r);
            b.column = 6'(c);
            b.top_char = 8'(tc);
            b.top_gap = tg;
            b.bottom_char = 8'(bc);
            b.bottom_gap = bg;
            b.overflow = ov;
            b.last = 0;
            pending_beats.insert(pending_beats.size(), b);
        endfunction

        function void push_ignored();
            push(lasc_pkg::KIND_CELL, 0, 0, 0, 0, 0, 0, 0, 1);
            pending_beats[$].last = 1;
        endfunction

        // score one column against all stored rows
        function void score_column(logic [7:0] sym);
            int above;
            int diag_in;
            int lsrc;
            int up_s;
            int left_s;
            int diag_s;
            int best;
            lasc_pkg::dir_t d;
            int c;
            c = n_cols;
            above = 0;
            diag_in = 0;
            if (c >= lasc_pkg::MAX_LEN) begin
                push_ignored();
                return;
            end
            col_seq[c] = sym;
            n_cols++;
            for (int i = 1; i <= n_rows; i++) begin
                lsrc = col_scores[i-1];
                up_s = above - gap;
                left_s = lsrc - gap;
                diag_s = (row_seq[i-1] == sym) ? diag_in + bonus : diag_in - mismatch;
                if (i == 1 && c == 0) begin best = diag_s; d = lasc_pkg::DIR_DIAG; end
                else if (i == 1) begin best = left_s; d = lasc_pkg::DIR_LEFT; end
                else if (c == 0) begin best = up_s; d = lasc_pkg::DIR_UP; end
                else if (diag_s >= up_s && diag_s >= left_s) begin
                    best = diag_s; d = lasc_pkg::DIR_DIAG;
                end else if (up_s >= left_s) begin
                    best = up_s; d = lasc_pkg::DIR_UP;
                end else begin
                    best = left_s; d = lasc_pkg::DIR_LEFT;
                end
                if (best < 0) best = 0;
                if (best > 255) best = 255;
                dir_mem[(i-1)*lasc_pkg::MAX_LEN + c] = d;
                diag_in = lsrc;
                col_scores[i-1] = best;
                above = best;
                push(lasc_pkg::KIND_CELL, best, i, c + 1, 0, 0, 0, 0, 0);
            end
            if (n_rows > 0) pending_beats[$].last = 1;
        endfunction

        // final score then pairs walking back from the bottom-right cell
        function void walk_back();
            int i;
            int j;
            int fin;
            lasc_pkg::dir_t d;
            i = n_rows;
            j = n_cols;
            fin = (i > 0 && j > 0) ? col_scores[i-1] : 0;
            push(lasc_pkg::KIND_FINAL, fin, i, j, 0, 0, 0, 0, 0);
            while (i != 0 && j != 0) begin
                d = dir_mem[(i-1)*lasc_pkg::MAX_LEN + (j-1)];
                if (d == lasc_pkg::DIR_DIAG) begin
                    push(lasc_pkg::KIND_PAIR, 0, i, j, int'(row_seq[i-1]), 0,
                         int'(col_seq[j-1]), 0, 0);
                    i--;
                    j--;
                end else if (d == lasc_pkg::DIR_UP) begin
                    push(lasc_pkg::KIND_PAIR, 0, i, j, int'(row_seq[i-1]), 0,
                         int'(lasc_pkg::GAP_CHAR), 1, 0);
                    i--;
                end else begin
                    push(lasc_pkg::KIND_PAIR, 0, i, j, int'(lasc_pkg::GAP_CHAR), 1,
                         int'(col_seq[j-1]), 0, 0);
                    j--;
                end
            end
            pending_beats[$].last = 1;
        endfunction

        function void note_input(lasc_pkg::action_t act, logic [7:0] sym);
            case (act)
                lasc_pkg::ACT_ROW: begin
                    if (n_rows >= lasc_pkg::MAX_LEN || n_cols != 0) push_ignored();
                    else begin
                        row_seq[n_rows] = sym;
                        n_rows++;
                    end
                end
                lasc_pkg::ACT_COL: score_column(sym);
                lasc_pkg::ACT_TB:  walk_back();
                default: begin
                    n_rows = 0;
                    n_cols = 0;
                    foreach (col_scores[i]) col_scores[i] = 0;
                end
            endcase
        endfunction

        function void cmp(string name, int e, int a);
            if (e != a) begin
                $error("%s: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(logic [47:0] d, logic lst);
            align_beat_t e;
            n_checked++;
            if (pending_beats.size() == 0) begin
                $error("output beat with nothing expected: data %h", d);
                errors++;
                return;
            end
            e = pending_beats.pop_front();
            cmp("kind", int'(e.kind), int'(d[1:0]));
            cmp("score", int'(e.score), int'(d[9:2]));
            cmp("row", int'(e.row), int'(d[15:10]));
            cmp("column", int'(e.column), int'(d[21:16]));
            cmp("top_char", int'(e.top_char), int'(d[29:22]));
            cmp("top_gap", int'(e.top_gap), int'(d[30]));
            cmp("bottom_char", int'(e.bottom_char), int'(d[38:31]));
            cmp("bottom_gap", int'(e.bottom_gap), int'(d[39]));
            cmp("overflow", int'(e.overflow), int'(d[40]));
            cmp("last", int'(e.last), int'(lst));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [2:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // action[1:0], symbol[9:2]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // kind, score, row, column, top_char, top_gap,
                            // bottom_char, bottom_gap, overflow
    logic        m_tlast;

    align_scoreboard sb;
    bit quiet;
    int hold_trig;
    int hold_seen;
    int hold_left;
    int stall_left;
    int idle_cnt;
    int n_sent;
    int n_seqs;
    int n_cfg;

    local_alignment_score_traceback_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // result side: check beats, random stalls, long hold on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
            if (hold_trig != hold_seen) begin
                hold_seen = hold_trig;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 0;
            end else begin
                if (!quiet && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 16);
                m_tready <= 1;
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cnt = 0;
        else idle_cnt++;
        if (idle_cnt >= 20000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send(lasc_pkg::action_t act, logic [7:0] sym);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {6'd0, sym, act};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(act, sym);
        n_sent++;
    endtask

    // let every expected beat arrive, then allow the core to settle
    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending_beats.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    // one register write; the caller drops the write enable afterwards
    task automatic write_reg(lasc_pkg::reg_idx_t idx, logic [2:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        sb.set_reg(idx, int'(val));
        n_cfg++;
    endtask

    task automatic set_penalties(logic [2:0] mb, logic [2:0] mm, logic [2:0] gp);
        drain();
        write_reg(lasc_pkg::REG_MATCH, mb);
        write_reg(lasc_pkg::REG_MISMATCH, mm);
        write_reg(lasc_pkg::REG_GAP, gp);
        cfg_we <= 0;
    endtask

    function automatic logic [7:0] pick_sym();
        return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(65, 68))
                                           : 8'($urandom_range(0, 255));
    endfunction

    // clear, load rows, score columns, walk back
    task automatic run_alignment(int nr, int nc);
        send(lasc_pkg::ACT_CLEAR, pick_sym());
        repeat (nr) send(lasc_pkg::ACT_ROW, pick_sym());
        repeat (nc) send(lasc_pkg::ACT_COL, pick_sym());
        if ($urandom_range(0, 5) == 0) send(lasc_pkg::ACT_ROW, pick_sym());
        send(lasc_pkg::ACT_TB, pick_sym());
        n_seqs++;
    endtask

    initial begin
        int nr;
        int nc;
        sb = new();
        sb.reset_state();
        aresetn = 0;
        cfg_we = 0;
        cfg_index = lasc_pkg::REG_MATCH;
        cfg_data = 0;
        s_tvalid = 0;
        s_tdata = 0;
        hold_trig = 0;
        hold_seen = 0;
        hold_left = 0;
        stall_left = 0;
        quiet = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty traceback, column without rows, late row, extremes
        send(lasc_pkg::ACT_TB, 8'h00);
        send(lasc_pkg::ACT_COL, 8'hff);
        send(lasc_pkg::ACT_ROW, 8'h00);
        send(lasc_pkg::ACT_TB, 8'hff);
        send(lasc_pkg::ACT_CLEAR, 8'h00);
        send(lasc_pkg::ACT_ROW, 8'h00);
        send(lasc_pkg::ACT_ROW, 8'hff);
        send(lasc_pkg::ACT_ROW, 8'h41);
        send(lasc_pkg::ACT_COL, 8'hff);
        send(lasc_pkg::ACT_COL, 8'h00);
        send(lasc_pkg::ACT_COL, 8'h41);
        send(lasc_pkg::ACT_COL, 8'h42);
        send(lasc_pkg::ACT_ROW, 8'h41);
        send(lasc_pkg::ACT_TB, 8'h00);
        send(lasc_pkg::ACT_TB, 8'h00);
        set_penalties(3'd0, 3'd0, 3'd0);
        run_alignment(3, 4);
        set_penalties(3'd7, 3'd7, 3'd7);
        run_alignment(4, 3);

        // random sequences, with capacity cases and penalty changes mixed in
        while (n_sent < 420) begin
            if (n_seqs % 6 == 0) begin
                set_penalties(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                              3'($urandom_range(0, 7)));
            end
            if (n_seqs == 5) begin
                run_alignment(33, 2);
            end else if (n_seqs == 8) begin
                run_alignment(1, 33);
            end else if (n_seqs == 10) begin
                // receiver holds off while the sender keeps offering
                hold_trig++;
                run_alignment(6, 5);
            end else if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6))
                    send(lasc_pkg::action_t'($urandom_range(0, 3)),
                         8'($urandom_range(0, 255)));
            end else begin
                nr = ($urandom_range(0, 15) == 0) ? 32 : $urandom_range(1, 7);
                nc = ($urandom_range(0, 15) == 0) ? 32 : $urandom_range(1, 7);
                run_alignment(nr, nc);
            end
            if (n_sent > 360) quiet = 1;
        end

        drain();
        $display("covered %0d input beats in %0d alignments, %0d register writes,",
                 n_sent, n_seqs, n_cfg);
        $display("%0d output beats checked with idling on both sides", sb.n_checked);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/core/lasc_pkg.sv
rtl/core/lasc_ram.sv
rtl/core/lasc_ctrl.sv
rtl/core/lasc_dp.sv
rtl/core/local_alignment_score_traceback_core.sv
dv/tb_top.sv
